// ===== design/hsnd_pkg.sv =====
// Shared types, character constants and jamo lookup functions for the Hangul name decoder.
package hsnd_pkg;

    localparam int CHAR_W     = 7;
    localparam int PREFIX_LEN = 16;
    localparam int TAIL_MAX   = 7;
    localparam int COUNT_W    = 5;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [4:0]        t_jamo_idx;

    typedef struct packed {
        logic                      ok;
        logic [2:0]                len;
        t_char [TAIL_MAX-1:0]      chars;
    } t_tail_view;

    typedef struct packed {
        logic      found;
        t_jamo_idx idx;
    } t_lookup;

    localparam t_char CH_NUL = 7'h00;
    localparam t_char CH_US  = 7'h5F;
    localparam t_char CH_A   = 7'h41;
    localparam t_char CH_B   = 7'h42;
    localparam t_char CH_C   = 7'h43;
    localparam t_char CH_D   = 7'h44;
    localparam t_char CH_E   = 7'h45;
    localparam t_char CH_G   = 7'h47;
    localparam t_char CH_H   = 7'h48;
    localparam t_char CH_I   = 7'h49;
    localparam t_char CH_J   = 7'h4A;
    localparam t_char CH_K   = 7'h4B;
    localparam t_char CH_L   = 7'h4C;
    localparam t_char CH_M   = 7'h4D;
    localparam t_char CH_N   = 7'h4E;
    localparam t_char CH_O   = 7'h4F;
    localparam t_char CH_P   = 7'h50;
    localparam t_char CH_R   = 7'h52;
    localparam t_char CH_S   = 7'h53;
    localparam t_char CH_T   = 7'h54;
    localparam t_char CH_U   = 7'h55;
    localparam t_char CH_W   = 7'h57;
    localparam t_char CH_Y   = 7'h59;

    localparam t_char PREFIX_TEXT [PREFIX_LEN] = '{
        CH_H, CH_A, CH_N, CH_G, CH_U, CH_L, CH_US,
        CH_S, CH_Y, CH_L, CH_L, CH_A, CH_B, CH_L, CH_E, CH_US
    };

    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [4:0]  V_COUNT    = 5'd21;
    localparam logic [4:0]  T_COUNT    = 5'd28;
    localparam t_jamo_idx   NO_INITIAL = 5'd11;

    function automatic logic is_initial(input t_char c);
        logic r;
        unique case (c) inside
            CH_G, CH_N, CH_D, CH_R, CH_M, CH_B, CH_S,
            CH_J, CH_C, CH_K, CH_T, CH_P, CH_H: r = 1'b1;
            default:                            r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_vowel(input t_char c);
        logic r;
        unique case (c) inside
            CH_A, CH_E, CH_I, CH_O, CH_U, CH_W, CH_Y: r = 1'b1;
            default:                                  r = 1'b0;
        endcase
        return r;
    endfunction

    // Doubled forms exist only for G, D, B, S and J.
    function automatic t_lookup initial_lookup(input t_char c, input logic dbl);
        t_lookup r;
        r.found = 1'b1;
        r.idx   = NO_INITIAL;
        unique case (c)
            CH_G:    r.idx = dbl ? 5'd1  : 5'd0;
            CH_N:    begin r.idx = 5'd2;  r.found = !dbl; end
            CH_D:    r.idx = dbl ? 5'd4  : 5'd3;
            CH_R:    begin r.idx = 5'd5;  r.found = !dbl; end
            CH_M:    begin r.idx = 5'd6;  r.found = !dbl; end
            CH_B:    r.idx = dbl ? 5'd8  : 5'd7;
            CH_S:    r.idx = dbl ? 5'd10 : 5'd9;
            CH_J:    r.idx = dbl ? 5'd13 : 5'd12;
            CH_C:    begin r.idx = 5'd14; r.found = !dbl; end
            CH_K:    begin r.idx = 5'd15; r.found = !dbl; end
            CH_T:    begin r.idx = 5'd16; r.found = !dbl; end
            CH_P:    begin r.idx = 5'd17; r.found = !dbl; end
            CH_H:    begin r.idx = 5'd18; r.found = !dbl; end
            default: r.found = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_lookup vowel_lookup(input logic [1:0] vlen, input t_char a,
                                             input t_char b, input t_char c);
        t_lookup r;
        t_char   bm;
        t_char   cm;
        bm      = (vlen >= 2'd2) ? b : CH_NUL;
        cm      = (vlen == 2'd3) ? c : CH_NUL;
        r.found = 1'b1;
        r.idx   = '0;
        unique case ({vlen, a, bm, cm})
            {2'd1, CH_A, CH_NUL, CH_NUL}: r.idx = 5'd0;
            {2'd2, CH_A, CH_E,   CH_NUL}: r.idx = 5'd1;
            {2'd2, CH_Y, CH_A,   CH_NUL}: r.idx = 5'd2;
            {2'd3, CH_Y, CH_A,   CH_E  }: r.idx = 5'd3;
            {2'd2, CH_E, CH_O,   CH_NUL}: r.idx = 5'd4;
            {2'd1, CH_E, CH_NUL, CH_NUL}: r.idx = 5'd5;
            {2'd3, CH_Y, CH_E,   CH_O  }: r.idx = 5'd6;
            {2'd2, CH_Y, CH_E,   CH_NUL}: r.idx = 5'd7;
            {2'd1, CH_O, CH_NUL, CH_NUL}: r.idx = 5'd8;
            {2'd2, CH_W, CH_A,   CH_NUL}: r.idx = 5'd9;
            {2'd3, CH_W, CH_A,   CH_E  }: r.idx = 5'd10;
            {2'd2, CH_O, CH_E,   CH_NUL}: r.idx = 5'd11;
            {2'd2, CH_Y, CH_O,   CH_NUL}: r.idx = 5'd12;
            {2'd1, CH_U, CH_NUL, CH_NUL}: r.idx = 5'd13;
            {2'd3, CH_W, CH_E,   CH_O  }: r.idx = 5'd14;
            {2'd2, CH_W, CH_E,   CH_NUL}: r.idx = 5'd15;
            {2'd2, CH_W, CH_I,   CH_NUL}: r.idx = 5'd16;
            {2'd2, CH_Y, CH_U,   CH_NUL}: r.idx = 5'd17;
            {2'd2, CH_E, CH_U,   CH_NUL}: r.idx = 5'd18;
            {2'd2, CH_Y, CH_I,   CH_NUL}: r.idx = 5'd19;
            {2'd1, CH_I, CH_NUL, CH_NUL}: r.idx = 5'd20;
            default:                      r.found = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_lookup final_lookup(input logic [2:0] rlen, input t_char a,
                                             input t_char b);
        t_lookup r;
        t_char   am;
        t_char   bm;
        am      = (rlen >= 3'd1) ? a : CH_NUL;
        bm      = (rlen >= 3'd2) ? b : CH_NUL;
        r.found = 1'b1;
        r.idx   = '0;
        unique case ({rlen, am, bm})
            {3'd0, CH_NUL, CH_NUL}: r.idx = 5'd0;
            {3'd1, CH_G,   CH_NUL}: r.idx = 5'd1;
            {3'd2, CH_G,   CH_G  }: r.idx = 5'd2;
            {3'd2, CH_G,   CH_S  }: r.idx = 5'd3;
            {3'd1, CH_N,   CH_NUL}: r.idx = 5'd4;
            {3'd2, CH_N,   CH_J  }: r.idx = 5'd5;
            {3'd2, CH_N,   CH_H  }: r.idx = 5'd6;
            {3'd1, CH_D,   CH_NUL}: r.idx = 5'd7;
            {3'd1, CH_L,   CH_NUL}: r.idx = 5'd8;
            {3'd2, CH_L,   CH_G  }: r.idx = 5'd9;
            {3'd2, CH_L,   CH_M  }: r.idx = 5'd10;
            {3'd2, CH_L,   CH_B  }: r.idx = 5'd11;
            {3'd2, CH_L,   CH_S  }: r.idx = 5'd12;
            {3'd2, CH_L,   CH_T  }: r.idx = 5'd13;
            {3'd2, CH_L,   CH_P  }: r.idx = 5'd14;
            {3'd2, CH_L,   CH_H  }: r.idx = 5'd15;
            {3'd1, CH_M,   CH_NUL}: r.idx = 5'd16;
            {3'd1, CH_B,   CH_NUL}: r.idx = 5'd17;
            {3'd2, CH_B,   CH_S  }: r.idx = 5'd18;
            {3'd1, CH_S,   CH_NUL}: r.idx = 5'd19;
            {3'd2, CH_S,   CH_S  }: r.idx = 5'd20;
            {3'd2, CH_N,   CH_G  }: r.idx = 5'd21;
            {3'd1, CH_J,   CH_NUL}: r.idx = 5'd22;
            {3'd1, CH_C,   CH_NUL}: r.idx = 5'd23;
            {3'd1, CH_K,   CH_NUL}: r.idx = 5'd24;
            {3'd1, CH_T,   CH_NUL}: r.idx = 5'd25;
            {3'd1, CH_P,   CH_NUL}: r.idx = 5'd26;
            {3'd1, CH_H,   CH_NUL}: r.idx = 5'd27;
            default:                r.found = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/hangul_syllable_name_decode_core.sv =====
// Top level of the Hangul syllable name decoder: input stage, name state, tail parser and result register.
// The result register captures the result of a name as its last word leaves the input register.
// Throughput: one word per cycle; a result held on the output stalls only a last word.
// Only the last word of a name produces a result word; it is parsed as it leaves the input stage.
// Reset is synchronous and active low; it clears the handshake state and the per-name state.
module hangul_syllable_name_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_name_valid,
    output logic [15:0] o_code_point
);
    import hsnd_pkg::*;

    logic       s1_valid;
    t_char      s1_char;
    logic       s1_last;
    logic       out_free;
    logic       take;
    t_tail_view view;
    logic       p_valid;
    logic [15:0] p_code;

    logic        r_o_valid;
    logic        r_name_valid;
    logic [15:0] r_code_point;

    assign out_free = !r_o_valid || !i_stall;
    assign take     = s1_valid && (!s1_last || out_free);

    hsnd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .o_stall    (o_stall),
        .i_take     (take),
        .o_s1_valid (s1_valid),
        .o_s1_char  (s1_char),
        .o_s1_last  (s1_last)
    );

    hsnd_name_track u_name_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (s1_char),
        .i_last  (s1_last),
        .o_view  (view)
    );

    hsnd_tail_parse u_tail_parse (
        .i_view       (view),
        .o_name_valid (p_valid),
        .o_code_point (p_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s1_valid && s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_valid && s1_last) begin
            r_name_valid <= p_valid;
            r_code_point <= p_code;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_name_valid = r_name_valid;
    assign o_code_point = r_code_point;

endmodule

// ===== design/hsnd_in_stage.sv =====
// Input register stage: case folds each incoming word and holds it until the core takes it.
module hsnd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [15:0]    i_ch,
    input  logic           i_last,
    output logic           o_stall,
    input  logic           i_take,
    output logic           o_s1_valid,
    output hsnd_pkg::t_char o_s1_char,
    output logic           o_s1_last
);
    import hsnd_pkg::*;

    logic  r_valid;
    t_char r_char;
    logic  r_last;
    t_char n_char;

    // Only ASCII a..z fold; anything outside ASCII becomes zero.
    always_comb begin
        if (i_ch >= 16'h0080) begin
            n_char = CH_NUL;
        end else if (i_ch >= 16'h0061 && i_ch <= 16'h007A) begin
            n_char = i_ch[6:0] - 7'h20;
        end else begin
            n_char = i_ch[6:0];
        end
    end

    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= n_char;
            r_last <= i_last;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1_char  = r_char;
    assign o_s1_last  = r_last;

endmodule

// ===== design/hsnd_name_track.sv =====
// Per-name state: prefix check, character count, overflow flag and the buffered tail.
module hsnd_name_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  hsnd_pkg::t_char     i_char,
    input  logic                i_last,
    output hsnd_pkg::t_tail_view o_view
);
    import hsnd_pkg::*;

    logic               r_prefix_ok;
    logic [COUNT_W-1:0] r_count;
    logic               r_too_long;
    t_char              r_tail [TAIL_MAX];

    logic               n_prefix_ok;
    logic [COUNT_W-1:0] n_count;
    logic               n_too_long;
    logic               in_prefix;
    logic               in_tail;
    logic [2:0]         slot;

    assign in_prefix = (r_count < COUNT_W'(PREFIX_LEN));
    assign in_tail   = (r_count >= COUNT_W'(PREFIX_LEN))
                    && (r_count < COUNT_W'(PREFIX_LEN + TAIL_MAX));
    assign slot      = r_count[2:0];

    always_comb begin
        n_prefix_ok = r_prefix_ok && !(in_prefix && (PREFIX_TEXT[r_count[3:0]] != i_char));
        n_too_long  = r_too_long || (r_count >= COUNT_W'(PREFIX_LEN + TAIL_MAX));
        n_count     = (r_count == '1) ? r_count : r_count + COUNT_W'(1);
    end

    // The view includes the word being taken, so the tail can be parsed in the same cycle.
    always_comb begin
        for (int k = 0; k < TAIL_MAX; k++) begin
            o_view.chars[k] = (in_tail && slot == 3'(k)) ? i_char : r_tail[k];
        end
        o_view.len = n_count[2:0];
        o_view.ok  = n_prefix_ok && !n_too_long
                  && (n_count > COUNT_W'(PREFIX_LEN))
                  && (n_count <= COUNT_W'(PREFIX_LEN + TAIL_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_ok <= 1'b1;
            r_count     <= '0;
            r_too_long  <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_prefix_ok <= 1'b1;
                r_count     <= '0;
                r_too_long  <= 1'b0;
            end else begin
                r_prefix_ok <= n_prefix_ok;
                r_count     <= n_count;
                r_too_long  <= n_too_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && in_tail) begin
            r_tail[slot] <= i_char;
        end
    end

endmodule

// ===== design/hsnd_tail_parse.sv =====
// Splits the tail into initial, vowel and final jamo and composes the syllable code point.
module hsnd_tail_parse (
    input  hsnd_pkg::t_tail_view i_view,
    output logic                 o_name_valid,
    output logic [15:0]          o_code_point
);
    import hsnd_pkg::*;

    t_char      tc [8];
    logic       has_init;
    logic       dbl;
    t_lookup    init_r;
    t_jamo_idx  li;
    logic [2:0] pos;
    logic [1:0] vlen;
    t_lookup    vow_r;
    logic [2:0] q;
    logic [2:0] rlen;
    t_lookup    fin_r;
    logic [8:0] lv;
    logic [13:0] syl;
    logic [15:0] cp;

    always_comb begin
        for (int k = 0; k < TAIL_MAX; k++) begin
            tc[k] = i_view.chars[k];
        end
        tc[7] = CH_NUL;

        has_init = is_initial(tc[0]);
        dbl      = (i_view.len > 3'd1) && (tc[1] == tc[0]);
        init_r   = initial_lookup(tc[0], dbl);
        li       = has_init ? init_r.idx : NO_INITIAL;
        pos      = has_init ? (dbl ? 3'd2 : 3'd1) : 3'd0;

        // The vowel is taken greedily.
        vlen = 2'd0;
        if (pos < i_view.len) begin
            vlen = 2'd1;
            if ((pos + 3'd1 < i_view.len) && is_vowel(tc[pos + 3'd1])) begin
                vlen = 2'd2;
                if ((pos + 3'd2 < i_view.len) && is_vowel(tc[pos + 3'd2])) begin
                    vlen = 2'd3;
                end
            end
        end
        vow_r = vowel_lookup(vlen, tc[pos], tc[pos + 3'd1], tc[pos + 3'd2]);

        q     = pos + 3'(vlen);
        rlen  = i_view.len - q;
        fin_r = final_lookup(rlen, tc[q], tc[q + 3'd1]);

        lv  = 9'(li) * 9'(V_COUNT) + 9'(vow_r.idx);
        syl = 14'(lv) * 14'(T_COUNT) + 14'(fin_r.idx);
        cp  = SYL_BASE + 16'(syl);

        o_name_valid = i_view.ok && (!has_init || init_r.found) && vow_r.found && fin_r.found;
        o_code_point = o_name_valid ? cp : 16'h0000;
    end

endmodule

// ===== tb/sv/hangul_syllable_name_decode_core_tb.sv =====
// Self-checking testbench for the Hangul syllable name decoder core.
module hangul_syllable_name_decode_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREFIX_UNITS = 16;
    localparam int TAIL_UNITS   = 7;
    localparam int NO_LEAD      = 11;
    localparam int RANDOM_UNITS = 380;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    localparam int CASE_UPPER = 0;
    localparam int CASE_MIXED = 1;
    localparam int CASE_LOWER = 2;

    typedef struct {
        logic [15:0] ch;
        logic        last;
        bit          hold_out;
        bit          drain_first;
    } unit_t;

    typedef struct {
        logic        name_ok;
        logic [15:0] point;
    } syllable_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_ch    = 16'h0000;
    logic        i_last  = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_name_valid;
    logic [15:0] o_code_point;

    string name_prefix = "HANGUL_SYLLABLE_";
    string lead_set    = "GNDRMBSJCKTPH";
    string vowel_set   = "AEIOUWY";
    string lead_names [19] = '{"G", "GG", "N", "D", "DD", "R", "M", "B", "BB",
                               "S", "SS", "", "J", "JJ", "C", "K", "T", "P", "H"};
    string vowel_names [21] = '{"A", "AE", "YA", "YAE", "EO", "E", "YEO", "YE", "O",
                                "WA", "WAE", "OE", "YO", "U", "WEO", "WE", "WI",
                                "YU", "EU", "YI", "I"};
    string tail_names [28] = '{"", "G", "GG", "GS", "N", "NJ", "NH", "D", "L", "LG", "LM",
                               "LB", "LS", "LT", "LP", "LH", "M", "B", "BS",
                               "S", "SS", "NG", "J", "C", "K", "T", "P", "H"};

    unit_t     unit_queue[$];
    syllable_t expected_syllables[$];

    logic       pfx_good      = 1'b1;
    logic [4:0] units_seen    = 5'd0;
    logic       tail_overflow = 1'b0;
    logic [6:0] tail_buf [TAIL_UNITS];

    int error_count    = 0;
    int units_sent     = 0;
    int syllables_seen = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    bit bus_hold_out   = 1'b0;
    bit hold_request   = 1'b0;
    bit hold_done      = 1'b0;

    hangul_syllable_name_decode_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_name_valid (o_name_valid),
        .o_code_point (o_code_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [6:0] fold_unit(input logic [15:0] ch);
        if (ch >= 16'h0080) return 7'h00;
        if (ch >= 16'h0061 && ch <= 16'h007A) return ch[6:0] - 7'd32;
        return ch[6:0];
    endfunction

    function automatic bit in_letters(input string s, input logic [6:0] c);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == {1'b0, c}) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit seg_matches(input string s, input int start, input int len);
        if (s.len() != len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (s[i] != {1'b0, tail_buf[start + i]}) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit decode_tail(input int n, output logic [15:0] point);
        int         pos;
        int         li;
        int         vi;
        int         ti;
        int         vlen;
        bit         dbl;
        bit         found;
        logic [6:0] c;
        pos   = 0;
        li    = NO_LEAD;
        vlen  = 0;
        point = 16'h0000;
        c     = tail_buf[0];
        if (in_letters(lead_set, c)) begin
            dbl   = (n > 1) && (tail_buf[1] == c);
            found = 1'b0;
            for (int i = 0; i < 19 && !found; i++) begin
                if (lead_names[i][0] == {1'b0, c} &&
                    (!dbl || lead_names[i][1] == {1'b0, c})) begin
                    li    = i;
                    found = 1'b1;
                end
            end
            if (!found) return 1'b0;
            pos = dbl ? 2 : 1;
        end
        if (pos < n) begin
            vlen = 1;
            if (pos + 1 < n && in_letters(vowel_set, tail_buf[pos + 1])) begin
                vlen = 2;
                if (pos + 2 < n && in_letters(vowel_set, tail_buf[pos + 2])) vlen = 3;
            end
        end
        for (vi = 0; vi < 21; vi++) begin
            if (seg_matches(vowel_names[vi], pos, vlen)) break;
        end
        if (vi == 21) return 1'b0;
        pos += vlen;
        for (ti = 0; ti < 28; ti++) begin
            if (seg_matches(tail_names[ti], pos, n - pos)) break;
        end
        if (ti == 28) return 1'b0;
        point = 16'(32'hAC00 + (li * 21 + vi) * 28 + ti);
        return 1'b1;
    endfunction

    task automatic absorb_unit(input logic [15:0] ch, input logic last);
        logic [6:0]  c;
        int          seen;
        syllable_t   res;
        logic [15:0] point;
        c    = fold_unit(ch);
        seen = units_seen;
        if (seen < PREFIX_UNITS) begin
            if (name_prefix[seen] != {1'b0, c}) pfx_good = 1'b0;
        end else if (seen - PREFIX_UNITS < TAIL_UNITS) begin
            tail_buf[seen - PREFIX_UNITS] = c;
        end else begin
            tail_overflow = 1'b1;
        end
        if (units_seen < 5'd31) units_seen = units_seen + 5'd1;
        if (last) begin
            seen        = units_seen;
            res.name_ok = 1'b0;
            res.point   = 16'h0000;
            if (pfx_good && !tail_overflow && seen > PREFIX_UNITS &&
                seen - PREFIX_UNITS <= TAIL_UNITS) begin
                res.name_ok = decode_tail(seen - PREFIX_UNITS, point);
                if (res.name_ok) res.point = point;
            end
            expected_syllables.push_back(res);
            pfx_good      = 1'b1;
            units_seen    = 5'd0;
            tail_overflow = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        unit_t u;
        int    wait_cnt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            wait_cnt = send_gap;
            if (i_valid && !o_stall) begin
                absorb_unit(i_ch, i_last);
                if (bus_hold_out) hold_request <= 1'b1;
                units_sent++;
                wait_cnt = ((units_sent % 256) >= 192) ? 0 : $urandom_range(0, 3);
            end
            if (i_valid && o_stall) begin
                send_gap <= send_gap;
            end else if (wait_cnt > 0) begin
                i_valid  <= 1'b0;
                send_gap <= wait_cnt - 1;
            end else if (unit_queue.size() != 0 &&
                         !(unit_queue[0].drain_first && expected_syllables.size() != 0)) begin
                u = unit_queue.pop_front();
                i_ch         <= u.ch;
                i_last       <= u.last;
                bus_hold_out <= u.hold_out;
                i_valid      <= 1'b1;
                send_gap     <= 0;
            end else begin
                i_valid  <= 1'b0;
                send_gap <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        syllable_t exp;
        int        wait_cnt;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap <= 0;
        end else begin
            wait_cnt = recv_gap;
            if (o_valid && !i_stall) begin
                syllables_seen++;
                if (expected_syllables.size() == 0) begin
                    $error("result word with no pending name: name_valid=%0b code_point=%h",
                           o_name_valid, o_code_point);
                    error_count++;
                end else begin
                    exp = expected_syllables.pop_front();
                    if (o_name_valid !== exp.name_ok) begin
                        $error("name_valid mismatch: expected %0b actual %0b",
                               exp.name_ok, o_name_valid);
                        error_count++;
                    end
                    if (o_code_point !== exp.point) begin
                        $error("code_point mismatch: expected %h actual %h",
                               exp.point, o_code_point);
                        error_count++;
                    end
                end
                wait_cnt = ((syllables_seen % 24) >= 16) ? 0 : $urandom_range(0, 3);
            end
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_request && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                i_stall   <= 1'b1;
            end else if (wait_cnt != 0) begin
                i_stall  <= 1'b1;
                recv_gap <= wait_cnt - 1;
            end else begin
                i_stall  <= 1'b0;
                recv_gap <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_text(ref logic [15:0] units[$], input string s, input int case_mode);
        byte b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            if (b >= "A" && b <= "Z" &&
                (case_mode == CASE_LOWER || (case_mode == CASE_MIXED && $urandom_range(0, 1))))
                b = b + 8'd32;
            units.push_back({8'h00, b});
        end
    endtask

    task automatic commit_name(ref logic [15:0] units[$], input bit hold_out,
                               input bit drain_first);
        unit_t u;
        for (int i = 0; i < units.size(); i++) begin
            u.ch          = units[i];
            u.last        = (i == units.size() - 1);
            u.hold_out    = hold_out && (i == 0);
            u.drain_first = drain_first && (i == 0);
            unit_queue.push_back(u);
        end
    endtask

    task automatic queue_name(input string tail, input int case_mode);
        logic [15:0] units[$];
        add_text(units, name_prefix, case_mode);
        add_text(units, tail, case_mode);
        commit_name(units, 1'b0, 1'b0);
    endtask

    task automatic queue_odd_tail(input string head, input logic [15:0] odd_unit);
        logic [15:0] units[$];
        add_text(units, name_prefix, CASE_UPPER);
        add_text(units, head, CASE_UPPER);
        units.push_back(odd_unit);
        commit_name(units, 1'b0, 1'b0);
    endtask

    initial begin
        logic [15:0] units[$];
        int          planned;
        int          r;
        int          k;
        bit          first_random;

        queue_name("GA", CASE_UPPER);
        queue_name("HIH", CASE_UPPER);
        queue_name("GGYAE", CASE_MIXED);
        queue_name("jjweo", CASE_LOWER);
        queue_name("A", CASE_UPPER);
        queue_name("EU", CASE_UPPER);
        queue_name("LA", CASE_UPPER);
        queue_name("", CASE_UPPER);
        queue_name("SSWAELB", CASE_UPPER);
        queue_name("SSWAELBS", CASE_UPPER);
        queue_name("GAGAGAGAGAGAGAGAGAGAGAGA", CASE_UPPER);
        queue_name("NNA", CASE_UPPER);
        queue_name("HHA", CASE_UPPER);
        queue_name("KKWA", CASE_LOWER);
        queue_name("DDALG", CASE_UPPER);
        queue_name("GWAE", CASE_UPPER);
        queue_name("GWAEO", CASE_UPPER);
        queue_name("G", CASE_UPPER);
        queue_name("GANG", CASE_MIXED);
        queue_odd_tail("G", 16'h0141);
        queue_odd_tail("GA", 16'h0060);
        queue_odd_tail("GA", 16'h007B);
        units.delete();
        units.push_back(16'h0148);
        add_text(units, "ANGUL_SYLLABLE_GA", CASE_UPPER);
        commit_name(units, 1'b0, 1'b0);
        units.delete();
        add_text(units, "HANGUL_SYLLABLX_GA", CASE_UPPER);
        commit_name(units, 1'b0, 1'b0);
        units.delete();
        units.push_back(16'hFFFF);
        commit_name(units, 1'b0, 1'b0);
        units.delete();
        units.push_back(16'h0000);
        commit_name(units, 1'b0, 1'b0);

        // A run of one-word names while the output is held, so the core backs up.
        for (int i = 0; i < 40; i++) begin
            units.delete();
            units.push_back(16'($urandom_range(0, 65535)));
            commit_name(units, i == 0, 1'b0);
        end

        planned      = 0;
        first_random = 1'b1;
        while (planned < RANDOM_UNITS) begin
            units.delete();
            r = $urandom_range(0, 99);
            if (r < 80) begin
                add_text(units, name_prefix, $urandom_range(0, 2));
                add_text(units, {lead_names[$urandom_range(0, 18)],
                                 vowel_names[$urandom_range(0, 20)],
                                 tail_names[$urandom_range(0, 27)]}, $urandom_range(0, 2));
                if (r >= 60) begin
                    k = $urandom_range(0, 2);
                    if (k == 0) begin
                        r = $urandom_range(0, units.size() - 1);
                        units[r] = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(8'h41, 8'h5A));
                    end else if (k == 1) begin
                        r = $urandom_range(1, units.size() - 1);
                        while (units.size() > r) void'(units.pop_back());
                    end else begin
                        r = $urandom_range(1, 12);
                        for (int i = 0; i < r; i++)
                            units.push_back(16'($urandom_range(8'h41, 8'h5A)));
                    end
                end
            end else begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    units.push_back($urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 127)));
                end
            end
            commit_name(units, 1'b0, first_random);
            first_random = 1'b0;
            planned += units.size();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (unit_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_syllables.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== hangul_syllable_name_decode_core.f =====
design/hsnd_pkg.sv
design/hsnd_in_stage.sv
design/hsnd_name_track.sv
design/hsnd_tail_parse.sv
design/hangul_syllable_name_decode_core.sv
tb/sv/hangul_syllable_name_decode_core_tb.sv
